// File: design/evr_pkg.sv
// Shared constants, types and helpers for the Euler X-Y-Z vector rotator.
package evr_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 16;

  localparam int N_AXES = 3;
  localparam int AXIS_W = 2;

  localparam int OUT_W  = SAMPLE_BITS + 1;
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int PROD_W = OUT_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam int IN_TDATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

  localparam int Q_BITS    = ANGLE_BITS - 2;
  localparam int X_SHIFT   = 32 - ANGLE_BITS;
  localparam int RND_SHIFT = 30 - TRIG_FRAC_BITS;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [AXIS_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [AXIS_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [AXIS_W-1:0] REG_ANGLE_Z = 2'd2;

  typedef logic signed [OUT_W-1:0]  samp_t;
  typedef logic signed [TRIG_W-1:0] coef_t;
  typedef logic [ANGLE_BITS-1:0]    angle_t;

  typedef struct packed {
    samp_t z;
    samp_t y;
    samp_t x;
  } vec_t;

  localparam coef_t TRIG_ONE = coef_t'(1) <<< TRIG_FRAC_BITS;

  // Q30 magnitudes of the Taylor terms of sin(pi/2 * x)
  function automatic logic [30:0] poly_q30(input logic [2:0] k);
    logic [30:0] c;
    case (k)
      3'd0:    c = 31'd1686629713;
      3'd1:    c = 31'd693598668;
      3'd2:    c = 31'd85569306;
      3'd3:    c = 31'd5026995;
      3'd4:    c = 31'd172272;
      3'd5:    c = 31'd3864;
      3'd6:    c = 31'd61;
      3'd7:    c = 31'd1;
      default: c = 31'd0;
    endcase
    return c;
  endfunction

  // round half up at 2^30
  function automatic logic [31:0] rnd30(input logic [61:0] p);
    logic [61:0] t;
    t = p + (62'd1 << 29);
    return t[61:30];
  endfunction

endpackage

// File: design/evr_trig_gen.sv
// Sequential sine/cosine generator with one shared multiplier.
module evr_trig_gen import evr_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [N_AXES-1:0]              wr_axis,
  input  angle_t [N_AXES-1:0]            angle,
  output coef_t  [N_AXES-1:0]            cos_c,
  output coef_t  [N_AXES-1:0]            sin_c,
  output logic                           busy
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_LOAD = 8'b00000010,
    ST_SQ   = 8'b00000100,
    ST_USQ  = 8'b00001000,
    ST_HMUL = 8'b00010000,
    ST_HSUB = 8'b00100000,
    ST_FMUL = 8'b01000000,
    ST_FIN  = 8'b10000000
  } state_t;

  typedef enum logic [1:0] {
    SP_NONE = 2'd0,
    SP_ZERO = 2'd1,
    SP_ONE  = 2'd2
  } spec_t;

  localparam angle_t            ANG_QUARTER = angle_t'(1) << Q_BITS;
  localparam logic [Q_BITS:0]   QUARTER     = {1'b1, {Q_BITS{1'b0}}};
  localparam logic [32:0]       HALF_F      = (33'd1 << RND_SHIFT) >> 1;
  localparam logic [32:0]       ONE_33      = 33'd1 << TRIG_FRAC_BITS;

  state_t              state;
  logic [N_AXES-1:0]   pending;
  logic [N_AXES-1:0]   pending_next;
  logic [AXIS_W-1:0]   axis;
  logic [AXIS_W-1:0]   pick;
  logic                phase;
  logic [2:0]          k;
  logic                neg;
  spec_t               spec;
  logic [29:0]         x_q;
  logic [29:0]         u_q;
  logic [30:0]         acc;
  logic [61:0]         prod;
  coef_t               cos_q [N_AXES];
  coef_t               sin_q [N_AXES];

  angle_t              ang_sel;
  logic [1:0]          quad;
  logic [Q_BITS:0]     r_fold;
  logic [31:0]         r30;
  logic [32:0]         s_f;
  logic [TRIG_FRAC_BITS:0] mag;
  coef_t               coef;

  always_comb begin
    if (pending[0]) begin
      pick = REG_ANGLE_X;
    end else if (pending[1]) begin
      pick = REG_ANGLE_Y;
    end else begin
      pick = REG_ANGLE_Z;
    end
    pending_next = pending | wr_axis;
    if (state == ST_IDLE && (|pending)) begin
      pending_next = (pending & ~(N_AXES'(1) << pick)) | wr_axis;
    end
  end

  always_comb begin
    ang_sel = angle[axis] + (phase ? '0 : ANG_QUARTER);
    quad    = ang_sel[ANGLE_BITS-1 -: 2];
    r_fold  = {1'b0, ang_sel[Q_BITS-1:0]};
    if (quad[0]) begin
      r_fold = QUARTER - {1'b0, ang_sel[Q_BITS-1:0]};
    end
    r30 = rnd30(prod);
    s_f = ({1'b0, r30} + HALF_F) >> RND_SHIFT;
    if (s_f > ONE_33) begin
      s_f = ONE_33;
    end
    case (spec)
      SP_ZERO: mag = '0;
      SP_ONE:  mag = ONE_33[TRIG_FRAC_BITS:0];
      default: mag = s_f[TRIG_FRAC_BITS:0];
    endcase
    coef = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= '0;
      phase   <= 1'b0;
      axis    <= REG_ANGLE_X;
      for (int i = 0; i < N_AXES; i++) begin
        cos_q[i] <= TRIG_ONE;
        sin_q[i] <= '0;
      end
    end else begin
      pending <= pending_next;
      case (state)
        ST_IDLE: begin
          if (|pending) begin
            axis  <= pick;
            phase <= 1'b0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          neg <= quad[1];
          x_q <= {r_fold[Q_BITS-1:0], {X_SHIFT{1'b0}}};
          if (r_fold == '0) begin
            spec  <= SP_ZERO;
            state <= ST_FIN;
          end else if (r_fold[Q_BITS]) begin
            spec  <= SP_ONE;
            state <= ST_FIN;
          end else begin
            spec  <= SP_NONE;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          prod  <= 62'(x_q) * 62'(x_q);
          state <= ST_USQ;
        end
        ST_USQ: begin
          u_q   <= r30[29:0];
          acc   <= poly_q30(3'd7);
          k     <= 3'd6;
          state <= ST_HMUL;
        end
        ST_HMUL: begin
          prod  <= 62'(acc) * 62'(u_q);
          state <= ST_HSUB;
        end
        ST_HSUB: begin
          acc <= poly_q30(k) - r30[30:0];
          if (k == 3'd0) begin
            state <= ST_FMUL;
          end else begin
            k     <= k - 3'd1;
            state <= ST_HMUL;
          end
        end
        ST_FMUL: begin
          prod  <= 62'(x_q) * 62'(acc);
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!phase) begin
            cos_q[axis] <= coef;
            phase       <= 1'b1;
            state       <= ST_LOAD;
          end else begin
            sin_q[axis] <= coef;
            phase       <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      cos_c[i] = cos_q[i];
      sin_c[i] = sin_q[i];
    end
  end

  assign busy = (state != ST_IDLE) || (|pending);

  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    (|wr_axis) |=> busy)
    else $error("angle write did not start a coefficient update");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !phase)
    else $error("generator idle in the middle of an axis");

  a_horner_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FMUL) |-> (k == 3'd0))
    else $error("final product before all polynomial terms");

endmodule

// File: design/evr_rot_stage.sv
// One plane rotation: product stage, then sum and round stage.
module evr_rot_stage import evr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  samp_t a_in,
  input  samp_t b_in,
  input  samp_t p_in,
  input  logic  active,
  input  coef_t cos_c,
  input  coef_t sin_c,
  output logic  out_valid,
  input  logic  out_ready,
  output samp_t a_out,
  output samp_t b_out,
  output samp_t p_out
);

  localparam logic signed [SUM_W-1:0] STAGE_HALF = SUM_W'(1) << (TRIG_FRAC_BITS - 1);

  logic v1;
  logic v2;
  logic adv1;
  logic adv2;

  logic signed [PROD_W-1:0] pac;
  logic signed [PROD_W-1:0] pbs;
  logic signed [PROD_W-1:0] pas;
  logic signed [PROD_W-1:0] pbc;
  samp_t a1;
  samp_t b1;
  samp_t p1;
  logic  act1;

  logic signed [SUM_W-1:0] sum_a;
  logic signed [SUM_W-1:0] sum_b;
  logic signed [SUM_W-1:0] rnd_a;
  logic signed [SUM_W-1:0] rnd_b;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_comb begin
    sum_a = $signed({pac[PROD_W-1], pac}) - $signed({pbs[PROD_W-1], pbs});
    sum_b = $signed({pas[PROD_W-1], pas}) + $signed({pbc[PROD_W-1], pbc});
    rnd_a = (sum_a + STAGE_HALF) >>> TRIG_FRAC_BITS;
    rnd_b = (sum_b + STAGE_HALF) >>> TRIG_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      pac  <= a_in * cos_c;
      pbs  <= b_in * sin_c;
      pas  <= a_in * sin_c;
      pbc  <= b_in * cos_c;
      a1   <= a_in;
      b1   <= b_in;
      p1   <= p_in;
      act1 <= active;
    end
    if (adv2 && v1) begin
      a_out <= act1 ? rnd_a[OUT_W-1:0] : a1;
      b_out <= act1 ? rnd_b[OUT_W-1:0] : b1;
      p_out <= p1;
    end
  end

  assign out_valid = v2;

endmodule

// File: design/evr_skid.sv
// Output register with a skid entry.
module evr_skid import evr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  vec_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output vec_t out_data
);

  logic out_v;
  logic skid_v;
  vec_t skid_d;

  assign in_ready  = !skid_v;
  assign out_valid = out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && out_ready) begin
      if (skid_v) begin
        out_data <= skid_d;
        skid_v   <= 1'b0;
      end else if (in_valid) begin
        out_data <= in_data;
      end else begin
        out_v <= 1'b0;
      end
    end else if (in_valid && !skid_v) begin
      if (out_v) begin
        skid_d <= in_data;
        skid_v <= 1'b1;
      end else begin
        out_data <= in_data;
        out_v    <= 1'b1;
      end
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid entry held with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_v && !out_ready && !skid_v && in_valid) |=> skid_v)
    else $error("transfer during output stall not caught by skid entry");

endmodule

// File: design/euler_xyz_vector_rotator.sv
// Top level: APB angle registers, trig generator, X/Y/Z rotation pipeline.
//
// channel   | signals                             | content (low bit first)
// ----------+-------------------------------------+----------------------------------
// input     | s_tvalid s_tready s_tdata[47:0]     | in_x, in_y, in_z
// output    | m_tvalid m_tready m_tdata[55:0]     | out_x, out_y, out_z, zero pad
// config    | psel penable pwrite paddr pwdata    | angle_x @0, angle_y @4, angle_z @8
//
// One vector per cycle unless stalled; two registers per axis stage, plus output register.
// An angle write recomputes cosine and sine in the shared multiplier sequencer;
// s_tready is low while it runs.
// Reset sets all angles to zero and the coefficients to identity.
// A stall on m_tready first parks one transfer in the skid entry, then backs up the stages.
module euler_xyz_vector_rotator import evr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // in_x, in_y, in_z
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // out_x, out_y, out_z
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  angle_t [N_AXES-1:0] angle;
  coef_t  [N_AXES-1:0] cos_c;
  coef_t  [N_AXES-1:0] sin_c;
  logic   [N_AXES-1:0] wr_axis;
  logic   [N_AXES-1:0] active;
  logic   [AXIS_W-1:0] reg_idx;
  logic                cfg_wr;
  logic                trig_busy;
  logic                gate;

  samp_t in_x;
  samp_t in_y;
  samp_t in_z;

  logic  vx, rx, vy, ry, vz, rz;
  samp_t x1, y1, z1;
  samp_t x2, y2, z2;
  samp_t x3, y3, z3;
  vec_t  out_vec;
  logic  st_ready;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      wr_axis[i] = cfg_wr && (reg_idx == AXIS_W'(i));
      active[i]  = (angle[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
    end else begin
      for (int i = 0; i < N_AXES; i++) begin
        if (wr_axis[i]) begin
          angle[i] <= pwdata[ANGLE_BITS-1:0];
        end
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ANGLE_X: prdata = {{(CFG_DATA_W-ANGLE_BITS){angle[0][ANGLE_BITS-1]}}, angle[0]};
      REG_ANGLE_Y: prdata = {{(CFG_DATA_W-ANGLE_BITS){angle[1][ANGLE_BITS-1]}}, angle[1]};
      REG_ANGLE_Z: prdata = {{(CFG_DATA_W-ANGLE_BITS){angle[2][ANGLE_BITS-1]}}, angle[2]};
      default:     prdata = '0;
    endcase
  end

  evr_trig_gen u_trig (
    .clk     (clk),
    .rst     (rst),
    .wr_axis (wr_axis),
    .angle   (angle),
    .cos_c   (cos_c),
    .sin_c   (sin_c),
    .busy    (trig_busy)
  );

  assign gate     = !trig_busy && !cfg_wr;
  assign s_tready = st_ready && gate;

  assign in_x = {s_tdata[SAMPLE_BITS-1], s_tdata[SAMPLE_BITS-1:0]};
  assign in_y = {s_tdata[2*SAMPLE_BITS-1], s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]};
  assign in_z = {s_tdata[3*SAMPLE_BITS-1], s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]};

  // about X: (y, z)
  evr_rot_stage u_rot_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid && gate),
    .in_ready  (st_ready),
    .a_in      (in_y),
    .b_in      (in_z),
    .p_in      (in_x),
    .active    (active[0]),
    .cos_c     (cos_c[0]),
    .sin_c     (sin_c[0]),
    .out_valid (vx),
    .out_ready (rx),
    .a_out     (y1),
    .b_out     (z1),
    .p_out     (x1)
  );

  // about Y: (z, x)
  evr_rot_stage u_rot_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vx),
    .in_ready  (rx),
    .a_in      (z1),
    .b_in      (x1),
    .p_in      (y1),
    .active    (active[1]),
    .cos_c     (cos_c[1]),
    .sin_c     (sin_c[1]),
    .out_valid (vy),
    .out_ready (ry),
    .a_out     (z2),
    .b_out     (x2),
    .p_out     (y2)
  );

  // about Z: (x, y)
  evr_rot_stage u_rot_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vy),
    .in_ready  (ry),
    .a_in      (x2),
    .b_in      (y2),
    .p_in      (z2),
    .active    (active[2]),
    .cos_c     (cos_c[2]),
    .sin_c     (sin_c[2]),
    .out_valid (vz),
    .out_ready (rz),
    .a_out     (x3),
    .b_out     (y3),
    .p_out     (z3)
  );

  evr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vz),
    .in_ready  (rz),
    .in_data   ('{z: z3, y: y3, x: x3}),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_vec)
  );

  assign m_tdata = OUT_TDATA_W'(out_vec);

endmodule

// File: sim/euler_xyz_vector_rotator_test.sv
// Testbench for the Euler X-Y-Z vector rotator: random and directed vectors, checked per axis.
module euler_xyz_vector_rotator_test import evr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } sample_vec_t;

  typedef struct {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
  } rotated_vec_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // in_x, in_y, in_z
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // out_x, out_y, out_z, zero pad
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  sample_vec_t  vec_q[$];
  rotated_vec_t rotated_q[$];
  sample_vec_t  offered;

  logic [ANGLE_BITS-1:0] angle_val [N_AXES];
  longint                cos_c [N_AXES];
  longint                sin_c [N_AXES];

  bit  calm = 1'b0;
  int  errors = 0;
  int  cycles = 0;

  euler_xyz_vector_rotator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned taylor_q30(input int k);
    case (k)
      0: return 64'd1686629713;
      1: return 64'd693598668;
      2: return 64'd85569306;
      3: return 64'd5026995;
      4: return 64'd172272;
      5: return 64'd3864;
      6: return 64'd61;
      default: return 64'd1;
    endcase
  endfunction

  function automatic longint unsigned mul_q30(input longint unsigned a, input longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // sine in Q1.16 of an angle in binary angle units
  function automatic longint sine_q16(input logic [ANGLE_BITS-1:0] a);
    longint unsigned r, xq, u, acc, s;
    logic [1:0] quad;
    int k;
    quad = a[ANGLE_BITS-1 -: 2];
    r = a[Q_BITS-1:0];
    if (quad[0]) r = (64'd1 << Q_BITS) - r;
    if (r == 0) begin
      s = 0;
    end else if (r >= (64'd1 << Q_BITS)) begin
      s = 64'd1 << TRIG_FRAC_BITS;
    end else begin
      xq = r << X_SHIFT;
      u = mul_q30(xq, xq);
      acc = taylor_q30(7);
      for (k = 6; k >= 0; k--) acc = taylor_q30(k) - mul_q30(acc, u);
      s = mul_q30(xq, acc);
      s = (s + ((64'd1 << RND_SHIFT) >> 1)) >> RND_SHIFT;
      if (s > (64'd1 << TRIG_FRAC_BITS)) s = 64'd1 << TRIG_FRAC_BITS;
    end
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint round_q16(input longint v);
    return (v + (64'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
  endfunction

  function automatic rotated_vec_t rotate_vector(input sample_vec_t v);
    longint x, y, z, t0, t1;
    rotated_vec_t r;
    x = v.x;
    y = v.y;
    z = v.z;
    if (angle_val[REG_ANGLE_X] != 0) begin
      t0 = round_q16(y * cos_c[REG_ANGLE_X] - z * sin_c[REG_ANGLE_X]);
      t1 = round_q16(y * sin_c[REG_ANGLE_X] + z * cos_c[REG_ANGLE_X]);
      y = t0;
      z = t1;
    end
    if (angle_val[REG_ANGLE_Y] != 0) begin
      t0 = round_q16(x * cos_c[REG_ANGLE_Y] + z * sin_c[REG_ANGLE_Y]);
      t1 = round_q16(z * cos_c[REG_ANGLE_Y] - x * sin_c[REG_ANGLE_Y]);
      x = t0;
      z = t1;
    end
    if (angle_val[REG_ANGLE_Z] != 0) begin
      t0 = round_q16(x * cos_c[REG_ANGLE_Z] - y * sin_c[REG_ANGLE_Z]);
      t1 = round_q16(x * sin_c[REG_ANGLE_Z] + y * cos_c[REG_ANGLE_Z]);
      x = t0;
      y = t1;
    end
    r.x = x[OUT_W-1:0];
    r.y = y[OUT_W-1:0];
    r.z = z[OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    $display("mismatch on %s: got %0d, expected %0d", field, $signed(got), $signed(want));
    errors++;
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) rotated_q.push_back(rotate_vector(offered));
      if (!s_tvalid || s_tready) begin
        if (vec_q.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
          offered = vec_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {offered.z, offered.y, offered.x};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    rotated_vec_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (rotated_q.size() == 0) begin
          $display("transfer with no vector pending: %h", m_tdata);
          errors++;
        end else begin
          want = rotated_q.pop_front();
          if (m_tdata[OUT_W-1:0] !== want.x) report_mismatch("out_x", m_tdata[OUT_W-1:0], want.x);
          if (m_tdata[2*OUT_W-1:OUT_W] !== want.y)
            report_mismatch("out_y", m_tdata[2*OUT_W-1:OUT_W], want.y);
          if (m_tdata[3*OUT_W-1:2*OUT_W] !== want.z)
            report_mismatch("out_z", m_tdata[3*OUT_W-1:2*OUT_W], want.z);
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_ready();
    repeat (2) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // checked between edges so that the driver's and monitor's updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (vec_q.size() != 0 || s_tvalid || rotated_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_angle(input logic [AXIS_W-1:0] idx, input logic [ANGLE_BITS-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(CFG_DATA_W-ANGLE_BITS){val[ANGLE_BITS-1]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    angle_val[idx] = val;
    cos_c[idx] = sine_q16(ANGLE_BITS'(val + (1 << Q_BITS)));
    sin_c[idx] = sine_q16(val);
    wait_ready();
  endtask

  task automatic set_angles(input logic [ANGLE_BITS-1:0] ax, input logic [ANGLE_BITS-1:0] ay,
                            input logic [ANGLE_BITS-1:0] az);
    write_angle(REG_ANGLE_X, ax);
    write_angle(REG_ANGLE_Y, ay);
    write_angle(REG_ANGLE_Z, az);
  endtask

  task automatic push_vec(input int x, input int y, input int z);
    sample_vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    vec_q.push_back(v);
  endtask

  task automatic push_directed();
    push_vec(0, 0, 0);
    push_vec(32767, 32767, 32767);
    push_vec(-32768, -32768, -32768);
    push_vec(32767, -32768, 0);
    push_vec(-32768, 32767, -1);
    push_vec(1, -1, 1);
    push_vec(-1, 0, 32767);
    push_vec(0, -32768, 32767);
    push_vec(21845, -21846, 12345);
    push_vec(-32768, 0, 0);
    push_vec(0, -32768, 0);
    push_vec(0, 0, -32768);
  endtask

  function automatic logic [ANGLE_BITS-1:0] pick_angle();
    if ($urandom_range(9) >= 4) return ANGLE_BITS'($urandom);
    case ($urandom_range(7))
      0: return 16'sd0;
      1: return 16'sd1;
      2: return -16'sd1;
      3: return 16'sd16384;
      4: return -16'sd16384;
      5: return -16'sd32768;
      6: return 16'sd32767;
      default: return 16'sd8192;
    endcase
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return -32768;
          1: return 32767;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      1: return int'($urandom_range(16)) - 8;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic push_random(input int count);
    repeat (count) push_vec(rand_sample(), rand_sample(), rand_sample());
  endtask

  initial begin
    for (int i = 0; i < N_AXES; i++) begin
      angle_val[i] = '0;
      cos_c[i] = 64'sd1 <<< TRIG_FRAC_BITS;
      sin_c[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait_ready();

    push_directed();
    wait_drained();
    set_angles(16'sd32767, -16'sd32768, 16'sd16384);
    push_directed();
    wait_drained();

    for (int phase = 0; phase < 16; phase++) begin
      case (phase)
        0: set_angles(16'sd0, 16'sd0, 16'sd0);
        1: set_angles(-16'sd32768, -16'sd32768, -16'sd32768);
        2: set_angles(16'sd32767, 16'sd32767, 16'sd32767);
        default: set_angles(pick_angle(), pick_angle(), pick_angle());
      endcase
      calm = (phase == 5);
      if (phase == 8) begin
        push_random(60);
        wait_drained();
        push_random(60);
      end else begin
        push_random(120);
      end
      wait_drained();
      calm = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
